[rtl/vweld_pkg.sv]
// Shared constants, types and helpers for the vertex weld and boundary edge block.
`timescale 1ns / 1ps
package vweld_pkg;

    localparam int VERTEX_SLOTS = 1024;
    localparam int EDGE_SLOTS   = 1024;

    localparam int VIDX_W = $clog2(VERTEX_SLOTS);
    localparam int VCNT_W = VIDX_W + 1;
    localparam int EIDX_W = $clog2(EDGE_SLOTS);
    localparam int ECNT_W = EIDX_W + 1;
    localparam int SCAN_W = (VCNT_W > ECNT_W) ? VCNT_W : ECNT_W;

    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 11;
    localparam int SLOT_W    = 10;
    localparam int COORD_W   = 32;

    localparam int ENTRY_W = 2 * VIDX_W + 1;

    localparam logic [COORD_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] INF_BITS = 32'h7F80_0000;

    localparam logic CMD_CORNER = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] PHASE_LAST = 2'd2;
    localparam logic [1:0] EDGE_LAST  = 2'd2;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_VERTEX  = 3'd1,
        MODE_EDGE    = 3'd2,
        MODE_COMPACT = 3'd3,
        MODE_READ    = 3'd4
    } scan_mode_t;

    typedef struct packed {
        logic       capture;
        scan_mode_t mode;
        logic       scan_start;
        logic       vfound;
        logic       vappend;
        logic       phase_store;
        logic       phase_clear;
        logic       edge_begin;
        logic       edge_advance;
        logic       eremove;
        logic       eappend;
        logic       compact_end;
        logic       rd_hit;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic phase_full;
        logic edge_last;
        logic wp_full;
        logic out_free;
        logic is_read;
    } ctl_status_t;

    function automatic logic float_equal(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        return (a == b) || (((a | b) & MAG_MASK) == '0);
    endfunction

endpackage

[rtl/vweld_ctrl.sv]
// Sequencer for corner lookup, edge toggling, compaction and edge reads.
`timescale 1ns / 1ps
module vweld_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vweld_pkg::ctl_status_t status,
    output vweld_pkg::ctl_cmd_t    cmd
);
    import vweld_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_VSCAN   = 10'b00_0000_0010,
        S_CEND    = 10'b00_0000_0100,
        S_ESCAN   = 10'b00_0000_1000,
        S_COMPACT = 10'b00_0001_0000,
        S_EAPPEND = 10'b00_0010_0000,
        S_ENEXT   = 10'b00_0100_0000,
        S_RSCAN   = 10'b00_1000_0000,
        S_DONE    = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mode   = MODE_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = status.is_read ? S_RSCAN : S_VSCAN;
                end
            end
            S_VSCAN:
            begin
                cmd.mode = MODE_VERTEX;
                if (status.hit)
                begin
                    cmd.vfound = 1'b1;
                    state_next = S_CEND;
                end
                else if (status.exhausted)
                begin
                    cmd.vappend = 1'b1;
                    state_next  = S_CEND;
                end
            end
            S_CEND:
            begin
                if (status.phase_full)
                begin
                    cmd.edge_begin = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_ESCAN;
                end
                else
                begin
                    cmd.phase_store = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_ESCAN:
            begin
                cmd.mode = MODE_EDGE;
                if (status.hit)
                begin
                    cmd.eremove = 1'b1;
                    state_next  = S_ENEXT;
                end
                else if (status.exhausted)
                begin
                    if (status.wp_full)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_COMPACT;
                    end
                    else
                    begin
                        cmd.eappend = 1'b1;
                        state_next  = S_ENEXT;
                    end
                end
            end
            S_COMPACT:
            begin
                cmd.mode = MODE_COMPACT;
                if (status.exhausted)
                begin
                    cmd.compact_end = 1'b1;
                    state_next      = S_EAPPEND;
                end
            end
            S_EAPPEND:
            begin
                cmd.eappend = 1'b1;
                state_next  = S_ENEXT;
            end
            S_ENEXT:
            begin
                if (status.edge_last)
                begin
                    cmd.phase_clear = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.edge_advance = 1'b1;
                    cmd.scan_start   = 1'b1;
                    state_next       = S_ESCAN;
                end
            end
            S_RSCAN:
            begin
                cmd.mode = MODE_READ;
                if (status.hit)
                begin
                    cmd.rd_hit = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.exhausted)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_VSCAN || state_reg == S_RSCAN))
        else $error("accepted word did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPACT && status.exhausted) |=> (state_reg == S_EAPPEND))
        else $error("compaction not followed by append");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_free) |=> (state_reg == S_IDLE))
        else $error("result load did not return to idle");

endmodule

[rtl/vweld_dp.sv]
// Datapath: position and edge memories, scan pipeline, counters and result register.
`timescale 1ns / 1ps
module vweld_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  vweld_pkg::ctl_cmd_t              cmd,
    output vweld_pkg::ctl_status_t           status,
    input  logic                             in_command,
    input  logic [vweld_pkg::COORD_W-1:0]    in_x,
    input  logic [vweld_pkg::COORD_W-1:0]    in_z,
    input  logic [vweld_pkg::SLOT_W-1:0]     in_slot,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [vweld_pkg::OUT_IDX_W-1:0]  vertex_index,
    output logic                             is_new,
    output logic                             table_full,
    output logic                             edge_valid,
    output logic [vweld_pkg::OUT_IDX_W-1:0]  edge_first,
    output logic [vweld_pkg::OUT_IDX_W-1:0]  edge_second,
    output logic [vweld_pkg::OUT_CNT_W-1:0]  edge_count,
    output logic [vweld_pkg::COORD_W-1:0]    max_x_bits
);
    import vweld_pkg::*;

    // memories
    logic [2*COORD_W-1:0] pos_mem [VERTEX_SLOTS];
    logic [ENTRY_W-1:0]   edge_mem [EDGE_SLOTS];
    logic [2*COORD_W-1:0] pos_rd_reg;
    logic [ENTRY_W-1:0]   edge_rd_reg;

    // captured word
    logic               cmd_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] z_reg;
    logic [SLOT_W-1:0]  slot_reg;

    // scan pipeline
    logic [SCAN_W-1:0] scan_addr_reg;
    logic              rd_pend_reg;
    logic [SCAN_W-1:0] rd_idx_reg;
    logic [SCAN_W-1:0] seen_reg;
    logic [ECNT_W-1:0] wcomp_reg;

    // block state
    logic [VCNT_W-1:0]  vcount_reg;
    logic [ECNT_W-1:0]  wp_reg;
    logic [ECNT_W-1:0]  surv_reg;
    logic [1:0]         phase_reg;
    logic [VIDX_W-1:0]  c0_reg;
    logic [VIDX_W-1:0]  c1_reg;
    logic [COORD_W-1:0] maxx_reg;
    logic               ovf_reg;
    logic [1:0]         esel_reg;
    logic [VIDX_W-1:0]  elo_reg;
    logic [VIDX_W-1:0]  ehi_reg;

    // per-word results
    logic              vidx_reg;
    logic [VIDX_W-1:0] vid_reg;
    logic              new_reg;
    logic              evalid_reg;
    logic [VIDX_W-1:0] efirst_reg;
    logic [VIDX_W-1:0] esecond_reg;

    // result register
    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] o_vidx_reg;
    logic                 o_new_reg;
    logic                 o_full_reg;
    logic                 o_evalid_reg;
    logic [OUT_IDX_W-1:0] o_efirst_reg;
    logic [OUT_IDX_W-1:0] o_esecond_reg;
    logic [OUT_CNT_W-1:0] o_count_reg;
    logic [COORD_W-1:0]   o_maxx_reg;

    logic [SCAN_W-1:0] limit;
    logic              issue;
    logic              hit;
    logic              e_ok;
    logic [VIDX_W-1:0] e_lo;
    logic [VIDX_W-1:0] e_hi;
    logic [COORD_W-1:0] st_x;
    logic [COORD_W-1:0] st_z;
    logic              v_full;
    logic              e_full;
    logic              x_bigger;
    logic [1:0]        sel_new;
    logic [VIDX_W-1:0] pa;
    logic [VIDX_W-1:0] pb;
    logic              mem_we;
    logic [EIDX_W-1:0] mem_wa;
    logic [ENTRY_W-1:0] mem_wd;
    logic              comp_keep;

    assign {e_ok, e_lo, e_hi} = edge_rd_reg;
    assign {st_x, st_z}       = pos_rd_reg;
    assign v_full = (vcount_reg >= VCNT_W'(VERTEX_SLOTS));
    assign e_full = (wp_reg >= ECNT_W'(EDGE_SLOTS));

    assign limit = (cmd.mode == MODE_VERTEX) ? SCAN_W'(vcount_reg) : SCAN_W'(wp_reg);
    assign issue = (cmd.mode != MODE_NONE) && (scan_addr_reg < limit);

    always_comb
    begin
        case (cmd.mode)
            MODE_VERTEX:
                hit = rd_pend_reg && float_equal(st_x, x_reg) && float_equal(st_z, z_reg);
            MODE_EDGE:
                hit = rd_pend_reg && e_ok && (e_lo == elo_reg) && (e_hi == ehi_reg);
            MODE_READ:
                hit = rd_pend_reg && e_ok && (32'(seen_reg) == 32'(slot_reg));
            default:
                hit = 1'b0;
        endcase
    end

    assign comp_keep = (cmd.mode == MODE_COMPACT) && rd_pend_reg && e_ok;

    assign status.hit        = hit;
    assign status.exhausted  = !rd_pend_reg && (scan_addr_reg >= limit);
    assign status.phase_full = (phase_reg >= PHASE_LAST);
    assign status.edge_last  = (esel_reg == EDGE_LAST);
    assign status.wp_full    = e_full;
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.is_read    = (in_command == CMD_READ);

    // unsigned compare of positive non-NaN x against the running maximum
    assign x_bigger = !x_reg[COORD_W-1] && (x_reg != '0)
                      && ((x_reg & MAG_MASK) <= INF_BITS) && (x_reg > maxx_reg);

    // pick the corner pair for the edge about to be toggled
    assign sel_new = cmd.edge_begin ? 2'd0 : (esel_reg + 2'd1);
    always_comb
    begin
        case (sel_new)
            2'd0:
            begin
                pa = c0_reg;
                pb = c1_reg;
            end
            2'd1:
            begin
                pa = c1_reg;
                pb = vid_reg;
            end
            default:
            begin
                pa = vid_reg;
                pb = c0_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        if (cmd.eremove)
        begin
            mem_we = 1'b1;
            mem_wa = rd_idx_reg[EIDX_W-1:0];
            mem_wd = {1'b0, elo_reg, ehi_reg};
        end
        else if (cmd.eappend && !e_full)
        begin
            mem_we = 1'b1;
            mem_wa = wp_reg[EIDX_W-1:0];
            mem_wd = {1'b1, elo_reg, ehi_reg};
        end
        else if (comp_keep)
        begin
            mem_we = 1'b1;
            mem_wa = wcomp_reg[EIDX_W-1:0];
            mem_wd = edge_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vappend && !v_full)
            pos_mem[vcount_reg[VIDX_W-1:0]] <= {x_reg, z_reg};
        pos_rd_reg <= pos_mem[scan_addr_reg[VIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            edge_mem[mem_wa] <= mem_wd;
        edge_rd_reg <= edge_mem[scan_addr_reg[EIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_command;
            x_reg    <= in_x;
            z_reg    <= in_z;
            slot_reg <= in_slot;
        end
        if (cmd.edge_begin || cmd.edge_advance)
        begin
            elo_reg <= (pa < pb) ? pa : pb;
            ehi_reg <= (pa < pb) ? pb : pa;
        end
    end

    // scan control: issue one read per cycle, check it the next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            seen_reg      <= '0;
            wcomp_reg     <= '0;
        end
        else if (cmd.scan_start)
        begin
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            seen_reg      <= '0;
            wcomp_reg     <= '0;
        end
        else
        begin
            rd_pend_reg <= issue;
            rd_idx_reg  <= scan_addr_reg;
            if (issue)
                scan_addr_reg <= scan_addr_reg + 1'b1;
            if (cmd.mode == MODE_READ && rd_pend_reg && e_ok && !hit)
                seen_reg <= seen_reg + 1'b1;
            if (comp_keep)
                wcomp_reg <= wcomp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg  <= '0;
            wp_reg      <= '0;
            surv_reg    <= '0;
            phase_reg   <= '0;
            c0_reg      <= '0;
            c1_reg      <= '0;
            maxx_reg    <= '0;
            ovf_reg     <= 1'b0;
            esel_reg    <= '0;
            vidx_reg    <= 1'b0;
            vid_reg     <= '0;
            new_reg     <= 1'b0;
            evalid_reg  <= 1'b0;
            efirst_reg  <= '0;
            esecond_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                vidx_reg    <= 1'b0;
                vid_reg     <= '0;
                new_reg     <= 1'b0;
                evalid_reg  <= 1'b0;
                efirst_reg  <= '0;
                esecond_reg <= '0;
            end
            if (cmd.vfound)
            begin
                vidx_reg <= 1'b1;
                vid_reg  <= rd_idx_reg[VIDX_W-1:0];
            end
            if (cmd.vappend)
            begin
                if (!v_full)
                begin
                    vid_reg    <= vcount_reg[VIDX_W-1:0];
                    vcount_reg <= vcount_reg + 1'b1;
                    new_reg    <= 1'b1;
                    vidx_reg   <= 1'b1;
                    if (x_bigger)
                        maxx_reg <= x_reg;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                    vid_reg <= '0;
                end
            end
            if (cmd.phase_store)
            begin
                if (phase_reg[0])
                    c1_reg <= vid_reg;
                else
                    c0_reg <= vid_reg;
                phase_reg <= phase_reg + 2'd1;
            end
            if (cmd.phase_clear)
                phase_reg <= '0;
            if (cmd.edge_begin || cmd.edge_advance)
                esel_reg <= sel_new;
            if (cmd.eremove)
                surv_reg <= surv_reg - 1'b1;
            if (cmd.eappend)
            begin
                if (!e_full)
                begin
                    wp_reg   <= wp_reg + 1'b1;
                    surv_reg <= surv_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.compact_end)
                wp_reg <= wcomp_reg;
            if (cmd.rd_hit)
            begin
                evalid_reg  <= 1'b1;
                efirst_reg  <= e_lo;
                esecond_reg <= e_hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_vidx_reg    <= (cmd_reg == CMD_CORNER) ? OUT_IDX_W'(vid_reg) : '0;
            o_new_reg     <= new_reg;
            o_full_reg    <= ovf_reg;
            o_evalid_reg  <= evalid_reg;
            o_efirst_reg  <= OUT_IDX_W'(efirst_reg);
            o_esecond_reg <= OUT_IDX_W'(esecond_reg);
            o_count_reg   <= OUT_CNT_W'(surv_reg);
            o_maxx_reg    <= maxx_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = o_vidx_reg;
    assign is_new       = o_new_reg;
    assign table_full   = o_full_reg;
    assign edge_valid   = o_evalid_reg;
    assign edge_first   = o_efirst_reg;
    assign edge_second  = o_esecond_reg;
    assign edge_count   = o_count_reg;
    assign max_x_bits   = o_maxx_reg;

    assert property (@(posedge clk) disable iff (!rst_n) surv_reg <= wp_reg)
        else $error("more survivors than written edge slots");

    assert property (@(posedge clk) disable iff (!rst_n) $past(ovf_reg) |-> ovf_reg)
        else $error("overflow flag cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact_end |-> (wcomp_reg <= wp_reg))
        else $error("compaction grew the edge table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.vappend && !v_full) |=> (new_reg && vidx_reg))
        else $error("append did not flag a new vertex");

endmodule

[rtl/vertex_weld_and_boundary_edges.sv]
// Top level of the vertex weld and boundary edge block.
`timescale 1ns / 1ps
// Takes one word at a time (in_stall is high from acceptance until the result is
// loaded into the output register). A corner word scans the stored vertices in the
// position memory one entry per cycle, stopping early on a match. A corner that
// closes a triangle then toggles each of its edges, as a scan of the written edge
// slots; when an append finds the edge memory written to its end, a compaction
// pass runs first. A read word scans the edge slots until the requested survivor.
// The result register lets the next word in while a result waits.
module vertex_weld_and_boundary_edges
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [vweld_pkg::COORD_W-1:0]       corner_x,
    input  logic [vweld_pkg::COORD_W-1:0]       corner_z,
    input  logic [vweld_pkg::SLOT_W-1:0]        edge_slot,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [vweld_pkg::OUT_IDX_W-1:0]     vertex_index,
    output logic                                is_new,
    output logic                                table_full,
    output logic                                edge_valid,
    output logic [vweld_pkg::OUT_IDX_W-1:0]     edge_first,
    output logic [vweld_pkg::OUT_IDX_W-1:0]     edge_second,
    output logic [vweld_pkg::OUT_CNT_W-1:0]     edge_count,
    output logic [vweld_pkg::COORD_W-1:0]       max_x_bits
);
    import vweld_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    vweld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vweld_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_command   (command),
        .in_x         (corner_x),
        .in_z         (corner_z),
        .in_slot      (edge_slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .is_new       (is_new),
        .table_full   (table_full),
        .edge_valid   (edge_valid),
        .edge_first   (edge_first),
        .edge_second  (edge_second),
        .edge_count   (edge_count),
        .max_x_bits   (max_x_bits)
    );

endmodule
